>>> design/assert_macros.svh
// Assertion helpers shared by the design files.
// All checks sample on the rising clock and are off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge
`define KVPS_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication
`define KVPS_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define KVPS_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/kvps_pkg.sv
package kvps_pkg;

   // Longest key or value passed on; extra bytes are dropped
   localparam int MAX_FIELD_LEN = 1024;
   localparam int LEN_W         = $clog2(MAX_FIELD_LEN + 1);

   // Results one text byte can cause
   localparam int RES_MAX   = 3;
   localparam int RES_CNT_W = $clog2(RES_MAX + 1);
   localparam int RES_IDX_W = $clog2(RES_MAX);

   // Characters that steer the parse
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // Parse phase, one-hot
   typedef enum logic [4:0] {
      PH_SEEK_KEY = 5'b00001,
      PH_KEY      = 5'b00010,
      PH_SEEK_EQ  = 5'b00100,
      PH_SEEK_VAL = 5'b01000,
      PH_VAL      = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_SINGLE = 2'd1,
      QUOTE_DOUBLE = 2'd2
   } quote_type;

   typedef enum logic [1:0] {
      KIND_KEY  = 2'd0,
      KIND_VAL  = 2'd1,
      KIND_PAIR = 2'd2,
      KIND_END  = 2'd3
   } kind_type;

   // Parser state carried from byte to byte
   typedef struct packed {
      phase_type        phase;
      quote_type        quote;
      logic             esc;
      logic [LEN_W-1:0] key_len;
      logic [LEN_W-1:0] val_len;
      logic             ovf;
   } kvps_state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       ovf;
      logic       last;
   } kvps_result_type;

   typedef kvps_result_type [RES_MAX-1:0] kvps_res_vec_type;

   localparam kvps_state_type STATE_RESET = '{
      phase:   PH_SEEK_KEY,
      quote:   QUOTE_NONE,
      esc:     1'b0,
      key_len: '0,
      val_len: '0,
      ovf:     1'b0
   };

endpackage

>>> design/key_value_pair_splitter_top.sv
// Channel | Ports                                   | Carries
// --------+-----------------------------------------+------------------------------
// req     | req_valid, req_ready, req_char_byte     | one text byte per request
// rsp     | rsp_valid, rsp_ready, rsp_result_kind,  | one result per transfer
//         | rsp_data_byte, rsp_field_overflow,      |
//         | rsp_last_of_run                         |
//
// A request is taken every cycle while rsp_ready stays high and each byte yields at
// most one result; a byte with more results holds the buffer until all are taken.
// A byte moves from the input register through the parse step to the result buffer;
// while the buffer still holds results, the byte waits in the input register.
// Synchronous reset returns the parser to seeking a key and empties both stages.
// The input register takes a new request while results of the previous byte wait.
`include "assert_macros.svh"

module key_value_pair_splitter_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_field_overflow,
   output logic       rsp_last_of_run
);
   import kvps_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff,  in_byte_in;
   kvps_state_type        state_ff,    state_in;
   kvps_res_vec_type      buf_ff,      buf_in;
   logic [RES_CNT_W-1:0]  cnt_ff,      cnt_in;

   kvps_state_type        step_state;
   kvps_res_vec_type      step_res;
   logic [RES_CNT_W-1:0]  step_cnt;

   logic                  buf_free;
   logic                  proc_fire;
   logic                  req_fire;
   logic                  rsp_fire;

   // Parse step on the registered byte
   kvps_parse u_parse (
      .state_i   (state_ff),
      .char_i    (in_byte_ff),
      .state_o   (step_state),
      .res_o     (step_res),
      .res_cnt_o (step_cnt)
   );

   // Handshake and stage movement
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign buf_free  = (cnt_ff == '0) || (cnt_ff == RES_CNT_W'(1) && rsp_ready);
   assign proc_fire = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || proc_fire;
   assign req_fire  = req_valid && req_ready;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_char_byte;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Parser state advances once per processed byte
   always_comb begin
      state_in = proc_fire ? step_state : state_ff;
   end

   // Result buffer: load a whole run, or shift out one result
   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (proc_fire) begin
         buf_in = step_res;
         cnt_in = step_cnt;
      end else if (rsp_fire) begin
         for (int i = 0; i < RES_MAX - 1; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
         cnt_in = cnt_ff - RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= STATE_RESET;
         cnt_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      buf_ff     <= buf_in;
   end

   // Result outputs from the buffer head
   assign rsp_result_kind    = buf_ff[0].kind;
   assign rsp_data_byte      = buf_ff[0].data;
   assign rsp_field_overflow = buf_ff[0].ovf;
   assign rsp_last_of_run    = buf_ff[0].last;

   // Checks
   `KVPS_CHECK_NOW(a_no_overwrite, proc_fire,
      cnt_ff == '0 || (cnt_ff == RES_CNT_W'(1) && rsp_ready), "result buffer overwritten")
   `KVPS_CHECK_NOW(a_esc_in_field, state_ff.esc,
      state_ff.phase == PH_KEY || state_ff.phase == PH_VAL, "escape pending outside a field")
   `KVPS_CHECK(a_len_bound,
      state_ff.key_len <= LEN_W'(MAX_FIELD_LEN) && state_ff.val_len <= LEN_W'(MAX_FIELD_LEN),
      "field length beyond limit")
   `KVPS_CHECK_NOW(a_end_is_last, rsp_valid && rsp_result_kind == KIND_END,
      rsp_last_of_run, "text end not last of run")
   `KVPS_CHECK_NEXT(a_end_resets, proc_fire && in_byte_ff == CH_NUL,
      state_ff == STATE_RESET, "state not cleared at text end")

endmodule

>>> design/kvps_parse.sv
`include "assert_macros.svh"

// One parse step: current state and one text byte in, next state and
// up to three results out. Purely combinational.
module kvps_parse (
   input  kvps_pkg::kvps_state_type                 state_i,
   input  logic [7:0]                               char_i,
   output kvps_pkg::kvps_state_type                 state_o,
   output kvps_pkg::kvps_res_vec_type               res_o,
   output logic [kvps_pkg::RES_CNT_W-1:0]           res_cnt_o
);
   import kvps_pkg::*;

   // Append one result if there is room
   function automatic void push(inout kvps_res_vec_type v,
                                inout logic [RES_CNT_W-1:0] n,
                                input kind_type k, input logic [7:0] d, input logic o);
      if (n != RES_CNT_W'(RES_MAX)) begin
         v[n[RES_IDX_W-1:0]] = '{kind: k, data: d, ovf: o, last: 1'b0};
         n = n + RES_CNT_W'(1);
      end
   endfunction

   // Store one key or value byte, or note the overflow
   function automatic void field_byte(inout kvps_state_type s,
                                      inout kvps_res_vec_type v,
                                      inout logic [RES_CNT_W-1:0] n,
                                      input logic [7:0] d);
      if (s.phase == PH_VAL) begin
         if (s.val_len < LEN_W'(MAX_FIELD_LEN)) begin
            push(v, n, KIND_VAL, d, 1'b0);
            s.val_len = s.val_len + LEN_W'(1);
         end else begin
            s.ovf = 1'b1;
         end
      end else begin
         if (s.key_len < LEN_W'(MAX_FIELD_LEN)) begin
            push(v, n, KIND_KEY, d, 1'b0);
            s.key_len = s.key_len + LEN_W'(1);
         end else begin
            s.ovf = 1'b1;
         end
      end
   endfunction

   // Pair finished or text ended: drop per-pair state
   function automatic void clear_pair(inout kvps_state_type s);
      s.key_len = '0;
      s.val_len = '0;
      s.ovf     = 1'b0;
      s.quote   = QUOTE_NONE;
   endfunction

   always_comb begin : step
      kvps_state_type         s;
      kvps_res_vec_type       r;
      logic [RES_CNT_W-1:0]   n;
      logic                   take_b;
      logic                   start;
      logic                   in_field;
      logic                   cls;

      s        = state_i;
      r        = '0;
      n        = '0;
      take_b   = 1'b1;
      start    = 1'b0;
      in_field = 1'b0;
      cls      = 1'b0;

      // Pending backslash: escaped quote, or a literal backslash
      if (s.esc) begin
         s.esc = 1'b0;
         if (char_i == CH_SQUOTE || char_i == CH_DQUOTE) begin
            field_byte(s, r, n, char_i);
            take_b = 1'b0;
         end else begin
            field_byte(s, r, n, CH_BSLASH);
         end
      end

      if (take_b) begin
         if (char_i == CH_NUL) begin
            // End of text
            if (s.phase == PH_VAL) begin
               push(r, n, KIND_PAIR, 8'h00, s.ovf);
            end
            push(r, n, KIND_END, 8'h00, 1'b0);
            clear_pair(s);
            s.esc   = 1'b0;
            s.phase = PH_SEEK_KEY;
         end else begin
            unique case (s.phase)
               PH_SEEK_KEY: begin
                  if (char_i != CH_SPACE) begin
                     s.phase = PH_KEY;
                     start   = 1'b1;
                  end
               end
               PH_SEEK_VAL: begin
                  if (char_i != CH_SPACE) begin
                     s.phase = PH_VAL;
                     start   = 1'b1;
                  end
               end
               PH_KEY, PH_VAL: begin
                  in_field = 1'b1;
               end
               PH_SEEK_EQ: begin
                  if (char_i == CH_EQUALS) begin
                     s.phase = PH_SEEK_VAL;
                  end
               end
               default: begin
                  s.phase = PH_SEEK_KEY;
               end
            endcase

            // Opening quote, or the first byte of a bare word
            if (start) begin
               if (char_i == CH_SQUOTE) begin
                  s.quote = QUOTE_SINGLE;
               end else if (char_i == CH_DQUOTE) begin
                  s.quote = QUOTE_DOUBLE;
               end else begin
                  s.quote  = QUOTE_NONE;
                  in_field = 1'b1;
               end
            end

            // Byte inside a key or value
            if (in_field) begin
               cls = (s.quote == QUOTE_SINGLE && char_i == CH_SQUOTE) ||
                     (s.quote == QUOTE_DOUBLE && char_i == CH_DQUOTE) ||
                     (s.quote == QUOTE_NONE   && char_i == CH_SPACE);
               priority if (char_i == CH_BSLASH) begin
                  s.esc = 1'b1;
               end else if (cls) begin
                  if (s.phase == PH_KEY) begin
                     s.phase = PH_SEEK_EQ;
                     s.quote = QUOTE_NONE;
                  end else begin
                     push(r, n, KIND_PAIR, 8'h00, s.ovf);
                     clear_pair(s);
                     s.phase = PH_SEEK_KEY;
                  end
               end else if (s.phase == PH_KEY && s.quote == QUOTE_NONE &&
                            char_i == CH_EQUALS) begin
                  s.phase = PH_SEEK_VAL;
                  s.quote = QUOTE_NONE;
               end else begin
                  field_byte(s, r, n, char_i);
               end
            end
         end
      end

      // Mark the last result of this byte
      for (int i = 0; i < RES_MAX; i++) begin
         r[i].last = (RES_CNT_W'(i + 1) == n);
      end

      state_o   = s;
      res_o     = r;
      res_cnt_o = n;
   end

endmodule

>>> verif/tb_key_value_pair_splitter_top.sv
module tb_key_value_pair_splitter_top;
   import kvps_pkg::*;

   localparam int CLK_HALF    = 6;
   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_CHARS = 250;
   localparam int PRINT_CAP   = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_data_byte;
   logic       rsp_field_overflow;
   logic       rsp_last_of_run;

   // no idling on either side while set
   bit calm = 1'b0;

   int cycle_count = 0;
   int mismatches = 0;
   int chars_sent = 0;
   int results_checked = 0;
   int kind_count [4];
   int trunc_pairs = 0;

   // splitter state as predicted
   phase_type sp_phase;
   quote_type sp_quote;
   logic      sp_escape;
   int        sp_key_len;
   int        sp_val_len;
   logic      sp_trunc;

   // results of the byte being predicted, then all results still owed
   kvps_result_type step_res [RES_MAX];
   int              step_cnt;
   kvps_result_type expected_results [$];

   key_value_pair_splitter_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_byte      (req_char_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_field_overflow (rsp_field_overflow),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------
   function void clear_pair_state();
      sp_key_len = 0;
      sp_val_len = 0;
      sp_trunc   = 1'b0;
      sp_quote   = QUOTE_NONE;
   endfunction

   function void reset_parser();
      sp_phase  = PH_SEEK_KEY;
      sp_escape = 1'b0;
      clear_pair_state();
   endfunction

   function void add_result(kind_type k, logic [7:0] d, logic o);
      if (step_cnt < RES_MAX) begin
         step_res[step_cnt] = '{kind: k, data: d, ovf: o, last: 1'b0};
         step_cnt++;
      end
   endfunction

   // bytes past the field limit are dropped and remembered for the pair
   function void store_field_byte(logic [7:0] b);
      if (sp_phase == PH_VAL) begin
         if (sp_val_len < MAX_FIELD_LEN) begin
            add_result(KIND_VAL, b, 1'b0);
            sp_val_len++;
         end else begin
            sp_trunc = 1'b1;
         end
      end else begin
         if (sp_key_len < MAX_FIELD_LEN) begin
            add_result(KIND_KEY, b, 1'b0);
            sp_key_len++;
         end else begin
            sp_trunc = 1'b1;
         end
      end
   endfunction

   function bit closes_field(logic [7:0] b);
      return (sp_quote == QUOTE_SINGLE && b == CH_SQUOTE) ||
             (sp_quote == QUOTE_DOUBLE && b == CH_DQUOTE) ||
             (sp_quote == QUOTE_NONE && b == CH_SPACE);
   endfunction

   // one byte inside a key or a value
   function void field_char(logic [7:0] b);
      if (b == CH_BSLASH) begin
         sp_escape = 1'b1;
      end else if (closes_field(b)) begin
         if (sp_phase == PH_KEY) begin
            sp_phase = PH_SEEK_EQ;
            sp_quote = QUOTE_NONE;
         end else begin
            add_result(KIND_PAIR, 8'h00, sp_trunc);
            clear_pair_state();
            sp_phase = PH_SEEK_KEY;
         end
      end else if (sp_phase == PH_KEY && sp_quote == QUOTE_NONE && b == CH_EQUALS) begin
         sp_phase = PH_SEEK_VAL;
         sp_quote = QUOTE_NONE;
      end else begin
         store_field_byte(b);
      end
   endfunction

   // first non-space byte of a field picks the quoting
   function void open_field(logic [7:0] b, phase_type nxt);
      if (b != CH_SPACE) begin
         sp_phase = nxt;
         if (b == CH_SQUOTE) begin
            sp_quote = QUOTE_SINGLE;
         end else if (b == CH_DQUOTE) begin
            sp_quote = QUOTE_DOUBLE;
         end else begin
            sp_quote = QUOTE_NONE;
            field_char(b);
         end
      end
   endfunction

   function void parse_char(logic [7:0] b);
      if (b == CH_NUL) begin
         if (sp_phase == PH_VAL)
            add_result(KIND_PAIR, 8'h00, sp_trunc);
         add_result(KIND_END, 8'h00, 1'b0);
         reset_parser();
      end else begin
         case (sp_phase)
            PH_SEEK_KEY: open_field(b, PH_KEY);
            PH_KEY, PH_VAL: field_char(b);
            PH_SEEK_EQ: begin
               if (b == CH_EQUALS)
                  sp_phase = PH_SEEK_VAL;
            end
            PH_SEEK_VAL: open_field(b, PH_VAL);
            default: sp_phase = PH_SEEK_KEY;
         endcase
      end
   endfunction

   // queue every result one accepted byte owes
   function void predict_byte(logic [7:0] b);
      bit taken;
      taken    = 1'b0;
      step_cnt = 0;
      // pending backslash: escaped quote, or the backslash itself
      if (sp_escape) begin
         sp_escape = 1'b0;
         if (b == CH_SQUOTE || b == CH_DQUOTE) begin
            store_field_byte(b);
            taken = 1'b1;
         end else begin
            store_field_byte(CH_BSLASH);
         end
      end
      if (!taken)
         parse_char(b);
      if (step_cnt > 0)
         step_res[step_cnt-1].last = 1'b1;
      for (int i = 0; i < step_cnt; i++)
         expected_results.push_back(step_res[i]);
   endfunction

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------
   task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("cycle %0d: %s", cycle_count, what);
   endtask

   always @(posedge clock) begin : check_results
      kvps_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result kind %0d data %02h with nothing expected",
                                      rsp_result_kind, rsp_data_byte));
         end else begin
            want = expected_results.pop_front();
            if (rsp_result_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, expected %0d",
                                         rsp_result_kind, want.kind));
            if (rsp_data_byte !== want.data)
               report_mismatch($sformatf("data %02h, expected %02h",
                                         rsp_data_byte, want.data));
            if (rsp_field_overflow !== want.ovf)
               report_mismatch($sformatf("overflow %b, expected %b",
                                         rsp_field_overflow, want.ovf));
            if (rsp_last_of_run !== want.last)
               report_mismatch($sformatf("last %b, expected %b",
                                         rsp_last_of_run, want.last));
            results_checked++;
            kind_count[want.kind]++;
            if (want.kind == KIND_PAIR && want.ovf)
               trunc_pairs++;
         end
      end
   end

   // result side stalls about 30% of cycles except in calm stretches
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 30);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   // called at a falling edge, returns at a falling edge
   task automatic send_char(input logic [7:0] b);
      int gap;
      req_valid     <= 1'b1;
      req_char_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_byte(b);
      chars_sent++;
      @(negedge clock);
      if (!calm && $urandom_range(99) < 30) begin
         gap = $urandom_range(1, 2);
         req_valid     <= 1'b0;
         req_char_byte <= 8'($urandom_range(255));
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_spaces(input int n);
      repeat (n) send_char(CH_SPACE);
   endtask

   // nonzero byte with no parse meaning, mostly lowercase letters
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      if ($urandom_range(99) < 60)
         return 8'h61 + 8'($urandom_range(25));
      c = 8'($urandom_range(1, 255));
      while (c == CH_SPACE || c == CH_EQUALS || c == CH_BSLASH ||
             c == CH_SQUOTE || c == CH_DQUOTE)
         c = 8'($urandom_range(1, 255));
      return c;
   endfunction

   function automatic quote_type pick_quote();
      case ($urandom_range(3))
         2: return QUOTE_SINGLE;
         3: return QUOTE_DOUBLE;
         default: return QUOTE_NONE;
      endcase
   endfunction

   // one key or value with random content; open_end leaves off the closer
   task automatic send_field(input quote_type q, input bit is_key, input bit open_end,
                             output bit eq_done);
      int         len;
      int         pick;
      logic [7:0] qc;
      logic [7:0] odd;
      eq_done = 1'b0;
      qc  = (q == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
      len = (q == QUOTE_NONE) ? $urandom_range(1, 6) : $urandom_range(0, 6);
      if (q != QUOTE_NONE)
         send_char(qc);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            // escaped quote
            send_char(CH_BSLASH);
            send_char($urandom_range(1) ? CH_SQUOTE : CH_DQUOTE);
         end else if (pick < 18) begin
            // backslash kept as a plain byte
            send_char(CH_BSLASH);
            send_char(plain_char());
         end else if (pick < 26 && q != QUOTE_NONE) begin
            // bytes that only mean something outside quotes
            case ($urandom_range(2))
               0: odd = CH_SPACE;
               1: odd = CH_EQUALS;
               default: odd = (q == QUOTE_SINGLE) ? CH_DQUOTE : CH_SQUOTE;
            endcase
            send_char(odd);
         end else begin
            send_char(plain_char());
         end
      end
      if (open_end) begin
      end else if (q != QUOTE_NONE) begin
         send_char(qc);
      end else if (is_key && $urandom_range(1)) begin
         send_char(CH_EQUALS);
         eq_done = 1'b1;
      end else begin
         send_char(CH_SPACE);
      end
   endtask

   // well-formed text: a few pairs, then end of text
   task automatic send_text();
      int pairs;
      bit eq_done;
      bit open_end;
      pairs = $urandom_range(1, 4);
      for (int p = 0; p < pairs; p++) begin
         send_spaces($urandom_range(0, 2));
         send_field(pick_quote(), 1'b1, 1'b0, eq_done);
         if (!eq_done) begin
            send_spaces($urandom_range(0, 1));
            if ($urandom_range(9) == 0)
               send_char(plain_char());
            send_char(CH_EQUALS);
         end
         send_spaces($urandom_range(0, 2));
         open_end = (p == pairs - 1) && $urandom_range(1);
         send_field(pick_quote(), 1'b0, open_end, eq_done);
      end
      send_char(CH_NUL);
   endtask

   // noise, or a key that never gets its value
   task automatic send_broken_text();
      bit eq_done;
      case ($urandom_range(2))
         0: repeat ($urandom_range(3, 10)) send_char(8'($urandom_range(255)));
         1: send_field(pick_quote(), 1'b1, 1'b1, eq_done);
         default: begin
            send_field(pick_quote(), 1'b1, 1'b0, eq_done);
            if (!eq_done)
               send_char(CH_EQUALS);
         end
      endcase
      send_char(CH_NUL);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed_cases();
      logic [7:0] seq [$];
      seq = '{
         // empty key, lone backslash, double backslash before a quote
         CH_EQUALS, 8'hFF, CH_BSLASH, 8'h61, CH_BSLASH, CH_BSLASH, CH_DQUOTE, CH_SPACE,
         // quoted key, junk before '=', text ends right after a backslash in a value
         CH_SQUOTE, 8'h01, CH_DQUOTE, CH_SQUOTE, 8'h6A, 8'hFF, CH_EQUALS,
         CH_DQUOTE, CH_EQUALS, CH_BSLASH, CH_NUL,
         // text ends inside a key
         8'h80, CH_NUL,
         // bare key ended by '=', text ends inside the value
         8'h78, CH_EQUALS, 8'h79, CH_NUL
      };
      foreach (seq[i])
         send_char(seq[i]);
   endtask

   task automatic test_random_texts();
      int first;
      first = chars_sent;
      while (chars_sent - first < RANDOM_CHARS) begin
         calm = (chars_sent - first >= 100) && (chars_sent - first < 180);
         if ($urandom_range(99) < 70)
            send_text();
         else
            send_broken_text();
      end
      calm = 1'b0;
   endtask

   initial begin
      reset_parser();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_texts();
      req_valid <= 1'b0;

      // drain, then keep watching for stray results
      while (expected_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("sent %0d text bytes, checked %0d results", chars_sent, results_checked);
      $display("%0d key bytes, %0d value bytes, %0d pairs (%0d truncated), %0d text ends",
               kind_count[KIND_KEY], kind_count[KIND_VAL], kind_count[KIND_PAIR],
               trunc_pairs, kind_count[KIND_END]);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
